### src/rtcrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcrf_pkg
// Shared types and constants of the serial clock chip register file.
// ----------------------------------------------------------------------------
package rtcrf_pkg;

	localparam int RAM_BYTES_DEF = 31;
	localparam int ADDR_W        = 5;
	localparam int TIME_REGS     = 7;
	localparam int TIME_AW       = 3;

	localparam logic [ADDR_W-1:0] PROTECT_ADDR = 5'd7;
	localparam logic [7:0]        SECONDS_RST  = 8'h80;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_CMD   = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
	localparam logic [1:0] ST_PROTECTED = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

### src/rtcrf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcrf_cmd_if / rtcrf_rsp_if
// Valid/ready channels for command words and response words.
// ----------------------------------------------------------------------------
interface rtcrf_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] command_byte;
	logic [7:0] write_data;

	modport source (output valid, output command_byte, output write_data, input ready);
	modport sink (input valid, input command_byte, input write_data, output ready);
endinterface

interface rtcrf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] status;
	logic       clock_halted;

	modport source (output valid, output read_data, output status, output clock_halted,
		input ready);
	modport sink (input valid, input read_data, input status, input clock_halted,
		output ready);
endinterface
`default_nettype wire

### src/rtc_serial_register_file.sv
// The command word is registered, then executed in the execute state, and the
// response word is held valid in the respond state until it is taken; a new word
// is taken only back in idle after the idle, execute and respond sequence.
// Reset (asynchronous, active low): seconds register 0x80 (clock halted),
// other clock registers zero, write protect set, scratch RAM all zero.
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_serial_register_file
// Device side register interface of a serial real-time clock chip.
// ----------------------------------------------------------------------------
module rtc_serial_register_file #(
	parameter int RAM_BYTES = rtcrf_pkg::RAM_BYTES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rtcrf_cmd_if.sink    cmd,
	rtcrf_rsp_if.source  rsp
);
	import rtcrf_pkg::*;

	ctrl_cmd_t ctrl;

	rtcrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	rtcrf_dp #(
		.RAM_BYTES (RAM_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.command_byte (cmd.command_byte),
		.write_data   (cmd.write_data),
		.read_data    (rsp.read_data),
		.status       (rsp.status),
		.clock_halted (rsp.clock_halted)
	);

	// one word in flight: no new word while a response is pending
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !cmd.ready)
		else $error("command taken while response pending");

	// a taken word is executed before its response shows
	a_exec_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (!rsp.valid && !cmd.ready))
		else $error("response without execute cycle");

	// rejected transfers return zero data
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.read_data == 8'd0))
		else $error("nonzero data on rejected transfer");

	// the halt bit only moves when a word executes
	a_halt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && $past(rsp.valid)) |-> $stable(rsp.clock_halted))
		else $error("clock halt bit changed while response held");

endmodule
`default_nettype wire

### src/rtcrf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcrf_ctrl
// Sequencer: take a word, execute it in the datapath, hold the response.
// ----------------------------------------------------------------------------
module rtcrf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rtcrf_pkg::ctrl_cmd_t    ctrl
);
	import rtcrf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign ctrl.load = cmd_valid && cmd_ready;
	assign ctrl.exec = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: begin
				if (rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### src/rtcrf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtcrf_dp
// Command decode, clock registers, write protect, scratch RAM, response regs.
// ----------------------------------------------------------------------------
module rtcrf_dp #(
	parameter int RAM_BYTES = rtcrf_pkg::RAM_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rtcrf_pkg::ctrl_cmd_t ctrl,
	input  wire logic [7:0]           command_byte,
	input  wire logic [7:0]           write_data,
	output logic [7:0]                read_data,
	output logic [1:0]                status,
	output logic                      clock_halted
);
	import rtcrf_pkg::*;

	localparam int RAM_AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
	localparam logic [ADDR_W-1:0] RAM_LIMIT = ADDR_W'(RAM_BYTES);

	logic [7:0]        cmd_q;
	logic [7:0]        wdata_q;
	logic [7:0]        time_q [TIME_REGS];
	logic              prot_q;
	logic [7:0]        ram_q [RAM_BYTES];
	logic [7:0]        rd_q;
	logic [1:0]        st_q;

	logic [ADDR_W-1:0] addr;
	logic              is_read;
	logic              is_ram;
	logic [TIME_AW-1:0] time_idx;
	logic [RAM_AW-1:0] ram_idx;
	logic [7:0]        rd_d;
	logic [1:0]        st_d;
	logic              wr_time;
	logic              wr_prot;
	logic              wr_ram;

	assign addr     = cmd_q[5:1];
	assign is_read  = cmd_q[0];
	assign is_ram   = cmd_q[6];
	assign time_idx = addr[TIME_AW-1:0];
	assign ram_idx  = RAM_AW'(addr);

	// bad command wins over address fault, which wins over protection
	always_comb begin
		rd_d    = 8'd0;
		st_d    = ST_OK;
		wr_time = 1'b0;
		wr_prot = 1'b0;
		wr_ram  = 1'b0;
		priority if (!cmd_q[7]) begin
			st_d = ST_BAD_CMD;
		end else if (is_ram) begin
			priority if (addr >= RAM_LIMIT || RAM_BYTES > 31) begin
				st_d = ST_BAD_ADDR;
			end else if (is_read) begin
				rd_d = ram_q[ram_idx];
			end else if (prot_q) begin
				st_d = ST_PROTECTED;
			end else begin
				wr_ram = 1'b1;
			end
		end else begin
			priority if (addr > PROTECT_ADDR) begin
				st_d = ST_BAD_ADDR;
			end else if (addr == PROTECT_ADDR) begin
				if (is_read) begin
					rd_d = {prot_q, 7'd0};
				end else begin
					wr_prot = 1'b1;
				end
			end else if (is_read) begin
				rd_d = time_q[time_idx];
			end else if (prot_q) begin
				st_d = ST_PROTECTED;
			end else begin
				wr_time = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= command_byte;
			wdata_q <= write_data;
		end
		if (ctrl.exec) begin
			rd_q <= rd_d;
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIME_REGS; i++) begin
				time_q[i] <= (i == 0) ? SECONDS_RST : 8'd0;
			end
			prot_q <= 1'b1;
			for (int i = 0; i < RAM_BYTES; i++) begin
				ram_q[i] <= 8'd0;
			end
		end else if (ctrl.exec) begin
			if (wr_time) time_q[time_idx] <= wdata_q;
			if (wr_prot) prot_q <= wdata_q[7];
			if (wr_ram) ram_q[ram_idx] <= wdata_q;
		end
	end

	assign read_data    = rd_q;
	assign status       = st_q;
	assign clock_halted = time_q[0][7];

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial clock chip register file. A behavioral
// copy of the clock, write-protect and scratch RAM state predicts every reply
// word; directed transfers, random traffic, back-to-back bursts, a long
// receiver stall and a full drain are run; random and drain phases idle on both channels.
// ----------------------------------------------------------------------------
module tb;
	import rtcrf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int CMD_VALID_BIT = 7;
	localparam int CMD_RAM_BIT = 6;
	localparam int CMD_READ_BIT = 0;
	localparam logic [7:0] SEC_WRITE_CMD = 8'h80;
	localparam logic [7:0] SEC_READ_CMD = 8'h81;
	localparam logic [7:0] WP_WRITE_CMD = 8'h8E;
	localparam logic [7:0] WP_READ_CMD = 8'h8F;
	localparam logic [7:0] RAM_WRITE_CMD = 8'hC0;
	localparam logic [7:0] RAM_READ_CMD = 8'hC1;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] status;
		logic       clock_halted;
	} rtc_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	rtcrf_cmd_if cmd_if ();
	rtcrf_rsp_if rsp_if ();

	rtc_serial_register_file u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the chip state
	logic [7:0] clock_regs [0:TIME_REGS-1];
	logic       wp_flag;
	logic [7:0] ram_mirror [0:31];

	rtc_reply_t pending_replies[$];
	int mismatches = 0;
	int replies_seen = 0;
	int status_count [4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	bit quiet_mode = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	function automatic void clear_mirror();
		for (int i = 0; i < TIME_REGS; i++)
			clock_regs[i] = 8'h00;
		clock_regs[0] = SECONDS_RST;
		wp_flag = 1'b1;
		for (int i = 0; i < 32; i++)
			ram_mirror[i] = 8'h00;
	endfunction

	function automatic rtc_reply_t predict_transfer(input logic [7:0] cmd_b,
		input logic [7:0] wdata);
		rtc_reply_t r;
		logic [ADDR_W-1:0] addr;
		logic is_read;
		addr = cmd_b[5:1];
		is_read = cmd_b[CMD_READ_BIT];
		r.read_data = 8'h00;
		r.status = ST_OK;
		if (!cmd_b[CMD_VALID_BIT]) begin
			r.status = ST_BAD_CMD;
		end else if (cmd_b[CMD_RAM_BIT]) begin
			if (addr >= RAM_BYTES_DEF)
				r.status = ST_BAD_ADDR;
			else if (is_read)
				r.read_data = ram_mirror[addr];
			else if (wp_flag)
				r.status = ST_PROTECTED;
			else
				ram_mirror[addr] = wdata;
		end else if (addr > PROTECT_ADDR) begin
			r.status = ST_BAD_ADDR;
		end else if (addr == PROTECT_ADDR) begin
			// protect register write always goes through, only bit 7 is kept
			if (is_read)
				r.read_data = {wp_flag, 7'd0};
			else
				wp_flag = wdata[7];
		end else if (is_read) begin
			r.read_data = clock_regs[addr[TIME_AW-1:0]];
		end else if (wp_flag) begin
			r.status = ST_PROTECTED;
		end else begin
			clock_regs[addr[TIME_AW-1:0]] = wdata;
		end
		r.clock_halted = clock_regs[0][7];
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one command word: drive at the falling edge, wait for the handshake
	task automatic send_transfer(input logic [7:0] cmd_b, input logic [7:0] wdata);
		@(negedge clk);
		cmd_if.valid = 1'b1;
		cmd_if.command_byte = cmd_b;
		cmd_if.write_data = wdata;
		forever begin
			@(posedge clk);
			if (cmd_if.ready)
				break;
		end
		pending_replies.push_back(predict_transfer(cmd_b, wdata));
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			cmd_if.valid = 1'b0;
			cmd_if.command_byte = 8'($urandom);
			cmd_if.write_data = 8'($urandom);
		end
	endtask

	task automatic pick_transfer(output logic [7:0] cmd_b, output logic [7:0] wdata);
		int r;
		logic [ADDR_W-1:0] addr;
		logic ram_sel;
		r = $urandom_range(0, 99);
		wdata = 8'($urandom);
		ram_sel = 1'($urandom_range(0, 1));
		if (ram_sel)
			addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 31))
				: ADDR_W'($urandom_range(0, RAM_BYTES_DEF - 1));
		else
			addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(0, 31))
				: ADDR_W'($urandom_range(0, TIME_REGS - 1));
		if (r < 8) begin
			cmd_b = 8'($urandom);
		end else if (r < 16) begin
			// keep protection off most of the time so writes land
			cmd_b = WP_WRITE_CMD;
			wdata[7] = ($urandom_range(0, 3) == 0);
		end else if (r < 20) begin
			cmd_b = WP_READ_CMD;
		end else begin
			cmd_b = {1'b1, ram_sel, addr, 1'(($urandom_range(0, 1)))};
		end
	endtask

	task automatic send_random(input int n, input bit with_gaps);
		logic [7:0] c;
		logic [7:0] d;
		repeat (n) begin
			if (with_gaps && $urandom_range(0, 2) == 0)
				idle_cycles(pick_gap());
			pick_transfer(c, d);
			send_transfer(c, d);
		end
	endtask

	task automatic wait_drained();
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_transfer(SEC_READ_CMD, 8'h00);      // clock halted after reset
		send_transfer(WP_READ_CMD, 8'h00);
		send_transfer(SEC_WRITE_CMD, 8'h12);     // rejected, protected
		send_transfer(RAM_WRITE_CMD, 8'hFF);
		send_transfer(RAM_READ_CMD, 8'h00);
		send_transfer(8'h00, 8'h00);             // bit 7 clear
		send_transfer(8'h7F, 8'hFF);
		send_transfer(WP_WRITE_CMD, 8'h7F);      // low bits dropped, protect off
		send_transfer(WP_READ_CMD, 8'h00);
		send_transfer(SEC_WRITE_CMD, 8'h00);     // start the clock
		send_transfer(SEC_READ_CMD, 8'hFF);
		send_transfer(8'h8C, 8'hFF);             // last time register
		send_transfer(8'h8D, 8'h00);
		send_transfer(8'h90, 8'h55);             // clock address 8
		send_transfer(8'hBF, 8'h00);             // burst address
		send_transfer(8'hFC, 8'hA5);             // last RAM byte
		send_transfer(8'hFD, 8'h00);
		send_transfer(8'hFE, 8'h3C);             // RAM address 31
		send_transfer(8'hFF, 8'h00);
		send_transfer(8'h3E, 8'h00);             // bad command beats bad address
		send_transfer(SEC_WRITE_CMD, 8'h80);     // halt again
		send_transfer(WP_WRITE_CMD, 8'h80);
		send_transfer(8'hFE, 8'h00);             // bad address beats protection
		send_transfer(8'h82, 8'h59);
		send_transfer(WP_WRITE_CMD, 8'h00);
	endtask

	task automatic test_random_traffic(input int n);
		send_random(n, 1'b1);
	endtask

	task automatic test_back_to_back(input int n);
		quiet_mode = 1'b1;
		send_random(n, 1'b0);
		quiet_mode = 1'b0;
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 60;
		send_random(30, 1'b0);
	endtask

	task automatic test_drain_pause();
		send_random(20, 1'b1);
		idle_cycles(1);
		wait_drained();
		send_random(20, 1'b1);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_if.ready = 1'b0;
			hold_left--;
		end else if (quiet_mode) begin
			rsp_if.ready = 1'b1;
		end else if (stall_left > 0) begin
			rsp_if.ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			rsp_if.ready = 1'b0;
		end else begin
			rsp_if.ready = 1'b1;
		end
	end

	always @(posedge clk) begin : reply_check
		rtc_reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply word with none expected: data %02h status %0d halt %0b",
					$time, rsp_if.read_data, rsp_if.status, rsp_if.clock_halted);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				replies_seen++;
				status_count[want.status]++;
				if (rsp_if.read_data !== want.read_data) begin
					$display("%0t: read_data expected %02h actual %02h",
						$time, want.read_data, rsp_if.read_data);
					mismatches++;
				end
				if (rsp_if.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_if.status);
					mismatches++;
				end
				if (rsp_if.clock_halted !== want.clock_halted) begin
					$display("%0t: clock_halted expected %0b actual %0b",
						$time, want.clock_halted, rsp_if.clock_halted);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d replies outstanding", $time,
				pending_replies.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.command_byte = 8'h00;
		cmd_if.write_data = 8'h00;
		rsp_if.ready = 1'b0;
		clear_mirror();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(300);
		test_back_to_back(100);
		test_backpressure();
		test_drain_pause();
		test_random_traffic(200);
		idle_cycles(1);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("checked %0d reply words over directed, random, burst, stall and drain phases",
			replies_seen);
		$display("status mix: %0d ok, %0d bad command, %0d bad address, %0d write protected",
			status_count[ST_OK], status_count[ST_BAD_CMD], status_count[ST_BAD_ADDR],
			status_count[ST_PROTECTED]);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
src/rtcrf_pkg.sv
src/rtcrf_if.sv
src/rtcrf_ctrl.sv
src/rtcrf_dp.sv
src/rtc_serial_register_file.sv
bench/tb.sv
